// File: rtl/core/apht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apht_pkg: shared constants and types of the all-pairs hop route table
// Node and hop widths, request and result codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package apht_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int DEPTH     = MAX_NODES * MAX_NODES;
    localparam int CNT_W     = 5;
    localparam int HOP_W     = 5;
    localparam int CMD_W     = 2;
    localparam int RES_W     = 2;

    localparam int S_TDATA_W = ((2 * NODE_W + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NODE_W + HOP_W + 1 + 7) / 8) * 8;

    localparam logic [HOP_W-1:0] HOP_INF = 5'd31;

    localparam logic [CMD_W-1:0] CMD_LINK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SOLVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [RES_W-1:0] RES_SOLVE = 2'd0;
    localparam logic [RES_W-1:0] RES_MISS  = 2'd1;
    localparam logic [RES_W-1:0] RES_HIT   = 2'd2;

    typedef struct packed {
        logic             req_load;
        logic             link_we;
        logic             solve_start;
        logic             init_we;
        logic             adv_i;
        logic             adv_j;
        logic             adv_k;
        logic             rd_ik;
        logic             cap_ik;
        logic             rd_ij;
        logic             upd;
        logic             solve_fin;
        logic             lk_rd;
        logic             cap_dist;
        logic             walk_adv;
        logic             out_load;
        logic [RES_W-1:0] out_kind;
    } apht_cmd_t;

    typedef struct packed {
        logic i_last;
        logic j_last;
        logic k_last;
        logic lk_ok;
        logic dist_inf;
        logic walk_end;
        logic out_free;
        logic solved;
    } apht_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/apht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apht_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module apht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/core/apht_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apht_ctrl: request sequencer of the route table
// Steps link writes, the all-pairs solve sweep and the route walk.
// ----------------------------------------------------------------------------
module apht_ctrl
    import apht_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [CMD_W-1:0] in_cmd,
    output logic                  in_ready,
    input  wire apht_sts_t        sts,
    output apht_cmd_t             ctl
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_RD_IK  = 4'd2;
    localparam logic [3:0] ST_CAP_IK = 4'd3;
    localparam logic [3:0] ST_RD_IJ  = 4'd4;
    localparam logic [3:0] ST_UPD    = 4'd5;
    localparam logic [3:0] ST_LK_RD  = 4'd6;
    localparam logic [3:0] ST_LK_CHK = 4'd7;
    localparam logic [3:0] ST_WALK   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [RES_W-1:0] kind_reg;
    logic [RES_W-1:0] kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= RES_SOLVE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.req_load = 1'b1;
                    unique case (in_cmd)
                        CMD_LINK:
                        begin
                            ctl.link_we = 1'b1;
                        end
                        CMD_SOLVE:
                        begin
                            ctl.solve_start = 1'b1;
                            state_next      = ST_INIT;
                        end
                        CMD_LOOKUP:
                        begin
                            state_next = ST_LK_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                ctl.init_we = 1'b1;
                ctl.adv_j   = 1'b1;
                ctl.adv_i   = sts.j_last;
                if (sts.i_last && sts.j_last)
                begin
                    state_next = ST_RD_IK;
                end
            end
            ST_RD_IK:
            begin
                ctl.rd_ik  = 1'b1;
                state_next = ST_CAP_IK;
            end
            ST_CAP_IK:
            begin
                ctl.cap_ik = 1'b1;
                ctl.rd_ij  = 1'b1;
                state_next = ST_UPD;
            end
            ST_RD_IJ:
            begin
                ctl.rd_ij  = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ctl.upd   = 1'b1;
                ctl.adv_j = 1'b1;
                ctl.adv_i = sts.j_last;
                ctl.adv_k = sts.j_last && sts.i_last;
                if (!sts.j_last)
                begin
                    state_next = ST_RD_IJ;
                end
                else if (!sts.i_last || !sts.k_last)
                begin
                    state_next = ST_RD_IK;
                end
                else
                begin
                    ctl.solve_fin = 1'b1;
                    kind_next     = RES_SOLVE;
                    state_next    = ST_OUT;
                end
            end
            ST_LK_RD:
            begin
                if (!sts.lk_ok)
                begin
                    kind_next  = RES_MISS;
                    state_next = ST_OUT;
                end
                else
                begin
                    ctl.lk_rd  = 1'b1;
                    state_next = ST_LK_CHK;
                end
            end
            ST_LK_CHK:
            begin
                if (sts.dist_inf)
                begin
                    kind_next  = RES_MISS;
                    state_next = ST_OUT;
                end
                else
                begin
                    ctl.cap_dist = 1'b1;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.walk_end)
                begin
                    kind_next  = RES_HIT;
                    state_next = ST_OUT;
                end
                else
                begin
                    ctl.walk_adv = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_kind = kind_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/apht_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apht_dp: route table datapath
// Link store, hop and predecessor RAMs, loop counters, relax unit, result reg.
// ----------------------------------------------------------------------------
module apht_dp
    import apht_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_wdata,
    input  wire logic [NODE_W-1:0] in_src,
    input  wire logic [NODE_W-1:0] in_dst,
    input  wire logic              in_link,
    input  wire apht_cmd_t         ctl,
    output apht_sts_t              sts,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic                   out_solve_done,
    output logic [NODE_W-1:0]      out_next,
    output logic [HOP_W-1:0]       out_hop,
    output logic                   out_found
);

    localparam logic [NODE_W-1:0] STEP_LAST = NODE_W'(MAX_NODES - 1);

    logic [CNT_W-1:0]     node_count_reg;
    logic [MAX_NODES-1:0] link_reg [MAX_NODES];
    logic [NODE_W-1:0]    src_reg;
    logic [NODE_W-1:0]    dst_reg;
    logic [NODE_W-1:0]    i_reg;
    logic [NODE_W-1:0]    j_reg;
    logic [NODE_W-1:0]    k_reg;
    logic [CNT_W-1:0]     run_n_reg;
    logic [CNT_W-1:0]     solved_n_reg;
    logic                 solved_reg;
    logic [HOP_W-1:0]     dik_reg;
    logic [HOP_W-1:0]     dist_reg;
    logic [NODE_W-1:0]    cur_reg;
    logic [NODE_W-1:0]    step_reg;
    logic                 out_valid_reg;
    logic                 out_done_reg;
    logic [NODE_W-1:0]    out_next_reg;
    logic [HOP_W-1:0]     out_hop_reg;
    logic                 out_found_reg;

    logic [CNT_W-1:0]     n_eff;
    logic [NODE_W-1:0]    n_last;
    logic [HOP_W:0]       sum;
    logic [HOP_W-1:0]     via;
    logic                 improve;
    logic [HOP_W-1:0]     init_hop;

    logic [ADDR_W-1:0]    hop_a_raddr;
    logic [ADDR_W-1:0]    pred_raddr;
    logic [ADDR_W-1:0]    waddr;
    logic                 hop_a_re;
    logic                 pred_re;
    logic                 we;
    logic [HOP_W-1:0]     hop_wdata;
    logic [NODE_W-1:0]    pred_wdata;
    logic [HOP_W-1:0]     hop_a_rdata;
    logic [HOP_W-1:0]     hop_b_rdata;
    logic [NODE_W-1:0]    pred_rdata;

    // node count clamped to the range 1 .. MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (node_count_reg > CNT_W'(MAX_NODES))
        begin
            n_eff = CNT_W'(MAX_NODES);
        end
        else
        begin
            n_eff = node_count_reg;
        end
    end

    assign n_last = NODE_W'(run_n_reg - CNT_W'(1));

    // saturating relax through k
    assign sum = {1'b0, dik_reg} + {1'b0, hop_a_rdata};
    assign via = (dik_reg == HOP_INF || hop_a_rdata == HOP_INF || sum >= {1'b0, HOP_INF})
                 ? HOP_INF : sum[HOP_W-1:0];
    assign improve = via < hop_b_rdata;

    assign init_hop = (i_reg == j_reg) ? '0 :
                      (link_reg[i_reg][j_reg] ? HOP_W'(1) : HOP_INF);

    always_comb
    begin
        if (ctl.rd_ik)
        begin
            hop_a_raddr = {i_reg, k_reg};
        end
        else if (ctl.rd_ij)
        begin
            hop_a_raddr = {k_reg, j_reg};
        end
        else
        begin
            hop_a_raddr = {src_reg, dst_reg};
        end

        if (ctl.rd_ij)
        begin
            pred_raddr = {k_reg, j_reg};
        end
        else if (ctl.lk_rd)
        begin
            pred_raddr = {src_reg, dst_reg};
        end
        else
        begin
            pred_raddr = {src_reg, pred_rdata};
        end
    end

    assign hop_a_re   = ctl.rd_ik | ctl.rd_ij | ctl.lk_rd;
    assign pred_re    = ctl.rd_ij | ctl.lk_rd | ctl.walk_adv;
    assign waddr      = {i_reg, j_reg};
    assign we         = ctl.init_we | (ctl.upd & improve);
    assign hop_wdata  = ctl.init_we ? init_hop : via;
    assign pred_wdata = ctl.init_we ? i_reg : pred_rdata;

    apht_ram #(.WIDTH(HOP_W), .DEPTH(DEPTH)) u_hop_a (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (hop_wdata),
        .re    (hop_a_re),
        .raddr (hop_a_raddr),
        .rdata (hop_a_rdata)
    );

    apht_ram #(.WIDTH(HOP_W), .DEPTH(DEPTH)) u_hop_b (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (hop_wdata),
        .re    (ctl.rd_ij),
        .raddr ({i_reg, j_reg}),
        .rdata (hop_b_rdata)
    );

    apht_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_pred (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (pred_wdata),
        .re    (pred_re),
        .raddr (pred_raddr),
        .rdata (pred_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(MAX_NODES);
            for (int r = 0; r < MAX_NODES; r++)
            begin
                link_reg[r] <= '0;
            end
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            run_n_reg     <= CNT_W'(1);
            solved_n_reg  <= '0;
            solved_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (ctl.link_we)
            begin
                link_reg[in_src][in_dst] <= in_link;
            end
            if (ctl.solve_start)
            begin
                run_n_reg <= n_eff;
                i_reg     <= '0;
                j_reg     <= '0;
                k_reg     <= '0;
            end
            else
            begin
                if (ctl.adv_j)
                begin
                    j_reg <= sts.j_last ? '0 : j_reg + NODE_W'(1);
                end
                if (ctl.adv_i)
                begin
                    i_reg <= sts.i_last ? '0 : i_reg + NODE_W'(1);
                end
                if (ctl.adv_k)
                begin
                    k_reg <= k_reg + NODE_W'(1);
                end
            end
            if (ctl.solve_fin)
            begin
                solved_reg   <= 1'b1;
                solved_n_reg <= run_n_reg;
            end
            if (ctl.lk_rd)
            begin
                step_reg <= '0;
            end
            else if (ctl.walk_adv)
            begin
                step_reg <= step_reg + NODE_W'(1);
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.req_load)
        begin
            src_reg <= in_src;
            dst_reg <= in_dst;
        end
        if (ctl.cap_ik)
        begin
            dik_reg <= hop_a_rdata;
        end
        if (ctl.cap_dist)
        begin
            dist_reg <= hop_a_rdata;
        end
        if (ctl.lk_rd)
        begin
            cur_reg <= dst_reg;
        end
        else if (ctl.walk_adv)
        begin
            cur_reg <= pred_rdata;
        end
        if (ctl.out_load)
        begin
            case (ctl.out_kind)
                RES_MISS:
                begin
                    out_done_reg  <= 1'b0;
                    out_next_reg  <= src_reg;
                    out_hop_reg   <= HOP_INF;
                    out_found_reg <= 1'b0;
                end
                RES_HIT:
                begin
                    out_done_reg  <= 1'b0;
                    out_next_reg  <= cur_reg;
                    out_hop_reg   <= dist_reg;
                    out_found_reg <= 1'b1;
                end
                default:
                begin
                    out_done_reg  <= 1'b1;
                    out_next_reg  <= '0;
                    out_hop_reg   <= '0;
                    out_found_reg <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        sts.i_last   = i_reg == n_last;
        sts.j_last   = j_reg == n_last;
        sts.k_last   = k_reg == n_last;
        sts.lk_ok    = solved_reg && (CNT_W'(src_reg) < solved_n_reg)
                       && (CNT_W'(dst_reg) < solved_n_reg);
        sts.dist_inf = hop_a_rdata == HOP_INF;
        sts.walk_end = (pred_rdata == src_reg) || (step_reg == STEP_LAST);
        sts.out_free = !out_valid_reg || out_ready;
        sts.solved   = solved_reg;
    end

    assign out_valid      = out_valid_reg;
    assign out_solve_done = out_done_reg;
    assign out_next       = out_next_reg;
    assign out_hop        = out_hop_reg;
    assign out_found      = out_found_reg;

endmodule
`default_nettype wire

// File: rtl/core/all_pairs_hop_route_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// all_pairs_hop_route_table_top: all-pairs shortest hop route table
// Link store, Floyd-Warshall solve on hop counts, and first-hop route lookup.
// ----------------------------------------------------------------------------
// One request is taken at a time; the result register lets the next request
// in while a result waits. A link write gives no result. A lookup whose pair
// is out of range or unreachable ends with a miss; else it takes one
// predecessor step at a time (at most MAX_NODES - 1 steps), set by the
// registered read of the predecessor RAM feeding its own next address. A
// solve over n nodes runs an initialization pass of one entry per cycle, then
// the relax sweep over every k, i and j, with its reads paced by the single
// read port per RAM copy. A result that finds the result register still full
// holds its request in the output state until the register frees. No lookup
// finds a route before the first solve, and link writes take effect at the
// next solve.
module all_pairs_hop_route_table_top
    import apht_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // src_node, dst_node, link_up
    input  wire logic [CMD_W-1:0]     s_tuser,   // cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // next_node, hop_count, found
    output logic                      m_tuser,   // solve_done
    input  wire logic                 cfg_we,
    input  wire logic [CNT_W-1:0]     cfg_wdata
);

    apht_cmd_t         ctl;
    apht_sts_t         sts;
    logic [NODE_W-1:0] out_next;
    logic [HOP_W-1:0]  out_hop;
    logic              out_found;

    apht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    apht_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_src         (s_tdata[NODE_W-1:0]),
        .in_dst         (s_tdata[2*NODE_W-1:NODE_W]),
        .in_link        (s_tdata[2*NODE_W]),
        .ctl            (ctl),
        .sts            (sts),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_solve_done (m_tuser),
        .out_next       (out_next),
        .out_hop        (out_hop),
        .out_found      (out_found)
    );

    assign m_tdata = M_TDATA_W'({out_found, out_hop, out_next});

`ifndef SYNTHESIS
    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == CMD_SOLVE) |=> !s_tready)
        else $error("request taken during solve");

    a_found_finite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_found) |-> (out_hop != HOP_INF))
        else $error("found route with infinite hop count");

    a_found_solved: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser && out_found) |-> sts.solved)
        else $error("route found before any solve");
`endif

endmodule
`default_nettype wire
